@@ rtl/fgsc_pkg.sv @@
`default_nettype none
package fgsc_pkg;

    // field widths
    localparam int MODE_W  = 2;
    localparam int CODE_W  = 8;
    localparam int STAMP_W = 32;
    localparam int INDEX_W = 4;

    // default slot count
    localparam int SLOTS_DEFAULT = 16;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRAME   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic eval;
        logic apply;
    } t_fgsc_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_fgsc_stat;

endpackage
`default_nettype wire

@@ rtl/fgsc_ctrl.sv @@
`default_nettype none
module fgsc_ctrl
    import fgsc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  t_fgsc_stat  i_stat,
    output t_fgsc_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   apply_now;
    logic   take;

    // apply once the output register can be written
    assign apply_now = (r_state == S_APPLY) && !i_stat.out_busy;

    // a new request enters when idle or as the current one retires
    assign o_stall = !((r_state == S_IDLE) || apply_now);
    assign take    = i_valid && !o_stall;

    assign o_cmd.capture = take;
    assign o_cmd.eval    = (r_state == S_EVAL);
    assign o_cmd.apply   = apply_now;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (apply_now) n_state = take ? S_EVAL : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ rtl/fgsc_dp.sv @@
`default_nettype none
module fgsc_dp
    import fgsc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_fgsc_cmd           i_cmd,
    output t_fgsc_stat          o_stat,
    input  wire  [MODE_W-1:0]   i_mode,
    input  wire  [CODE_W-1:0]   i_character,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [INDEX_W-1:0]  o_slot_index,
    output logic                o_slot_valid,
    output logic                o_is_new,
    output logic [CODE_W-1:0]   o_slot_character
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // slot state
    logic [CODE_W-1:0]  r_code  [SLOTS];
    logic [STAMP_W-1:0] r_stamp [SLOTS];
    logic [SLOTS-1:0]   r_used;
    logic [SLOTS-1:0]   r_pend;
    logic [STAMP_W-1:0] r_gen;

    // captured request
    logic [MODE_W-1:0]  r_in_mode;
    logic [CODE_W-1:0]  r_in_char;

    // evaluated request
    logic [MODE_W-1:0]  r_mode;
    logic [CODE_W-1:0]  r_char;
    logic               r_hit_found;
    logic [IW-1:0]      r_hit_idx;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic               r_pop_found;
    logic [IW-1:0]      r_pop_idx;

    // output register
    logic               r_out_valid;
    logic [IW-1:0]      r_out_idx;
    logic               r_out_slot_valid;
    logic               r_out_new;
    logic [CODE_W-1:0]  r_out_char;

    logic [SLOTS-1:0]   hit_vec;
    logic [SLOTS-1:0]   free_vec;
    logic [SLOTS-1:0]   pop_vec;
    logic               hit_found;
    logic [IW-1:0]      hit_idx;
    logic               free_found;
    logic [IW-1:0]      free_idx;
    logic               pop_found;
    logic [IW-1:0]      pop_idx;
    logic [IW+INDEX_W-1:0] idx_ext;

    assign o_stat.out_busy = r_out_valid && i_stall;

    // per-slot match lanes
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            hit_vec[k]  = r_used[k] && (r_code[k] == r_in_char);
            free_vec[k] = !r_used[k] || (r_stamp[k] != r_gen);
            pop_vec[k]  = r_used[k] && r_pend[k];
        end
    end

    // lowest-index priority pick
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        pop_found  = 1'b0;
        pop_idx    = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hit_found = 1'b1;
                hit_idx   = IW'(k);
            end
            if (free_vec[k]) begin
                free_found = 1'b1;
                free_idx   = IW'(k);
            end
            if (pop_vec[k]) begin
                pop_found = 1'b1;
                pop_idx   = IW'(k);
            end
        end
    end

    // request capture and evaluation stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_mode <= i_mode;
            r_in_char <= i_character;
        end
        if (i_cmd.eval) begin
            r_mode       <= r_in_mode;
            r_char       <= r_in_char;
            r_hit_found  <= hit_found;
            r_hit_idx    <= hit_idx;
            r_free_found <= free_found;
            r_free_idx   <= free_idx;
            r_pop_found  <= pop_found;
            r_pop_idx    <= pop_idx;
        end
    end

    // slot state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_code[k]  <= '0;
                r_stamp[k] <= '0;
            end
            r_used <= '0;
            r_pend <= '0;
            r_gen  <= STAMP_W'(1);
        end else if (i_cmd.apply) begin
            case (r_mode)
                MODE_REQUEST: begin
                    if (r_hit_found) begin
                        r_stamp[r_hit_idx] <= r_gen;
                    end else if (r_free_found) begin
                        r_used[r_free_idx]  <= 1'b1;
                        r_pend[r_free_idx]  <= 1'b1;
                        r_code[r_free_idx]  <= r_char;
                        r_stamp[r_free_idx] <= r_gen;
                    end
                end
                MODE_POP: begin
                    if (r_pop_found) r_pend[r_pop_idx] <= 1'b0;
                end
                MODE_FRAME: begin
                    r_gen <= r_gen + STAMP_W'(1);
                end
                MODE_CLEAR: begin
                    for (int k = 0; k < SLOTS; k++) begin
                        r_code[k]  <= '0;
                        r_stamp[k] <= '0;
                    end
                    r_used <= '0;
                    r_pend <= '0;
                    r_gen  <= STAMP_W'(1);
                end
                default: begin
                    r_gen <= r_gen;
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_idx        <= '0;
            r_out_slot_valid <= 1'b0;
            r_out_new        <= 1'b0;
            r_out_char       <= '0;
            case (r_mode)
                MODE_REQUEST: begin
                    if (r_hit_found) begin
                        r_out_idx        <= r_hit_idx;
                        r_out_slot_valid <= 1'b1;
                    end else if (r_free_found) begin
                        r_out_idx        <= r_free_idx;
                        r_out_slot_valid <= 1'b1;
                        r_out_new        <= 1'b1;
                    end
                end
                MODE_POP: begin
                    if (r_pop_found) begin
                        r_out_idx        <= r_pop_idx;
                        r_out_slot_valid <= 1'b1;
                        r_out_char       <= r_code[r_pop_idx];
                    end
                end
                default: begin
                    r_out_new <= 1'b0;
                end
            endcase
        end
    end

    // low bits of the slot number
    assign idx_ext = {{INDEX_W{1'b0}}, r_out_idx};

    assign o_valid          = r_out_valid;
    assign o_slot_index     = idx_ext[INDEX_W-1:0];
    assign o_slot_valid     = r_out_slot_valid;
    assign o_is_new         = r_out_new;
    assign o_slot_character = r_out_char;

endmodule
`default_nettype wire

@@ rtl/frame_generation_slot_cache.sv @@
// an accepted request is captured, then evaluated and applied into the output register;
// a new request is taken only while idle or as the current one is applied, as the evaluate
// and apply steps share the slot state (parallel match and priority pick, then update)
// a stalled result holds the apply step, and with it the input, until it is taken
// reset: synchronous, active low; empties all slots and sets the generation to 1
`default_nettype none
module frame_generation_slot_cache
    import fgsc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [MODE_W-1:0]   i_mode,
    input  wire  [CODE_W-1:0]   i_character,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [INDEX_W-1:0]  o_slot_index,
    output logic                o_slot_valid,
    output logic                o_is_new,
    output logic [CODE_W-1:0]   o_slot_character
);

    t_fgsc_cmd  cmd;
    t_fgsc_stat stat;

    // sequencing
    fgsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // slot state, match and output register
    fgsc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_character      (i_character),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_slot_index     (o_slot_index),
        .o_slot_valid     (o_slot_valid),
        .o_is_new         (o_is_new),
        .o_slot_character (o_slot_character)
    );

endmodule
`default_nettype wire
